>>> rtl/core/swk_pkg.sv
// Shared types, constants and the arctangent table of the swerve kinematics block.
package swk_pkg;

  localparam int NUM_MODULES      = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Module velocity components, signed, 1/16 inch per second.
  localparam int VW = 22;
  // CORDIC datapath: velocity scaled by 2^30 plus gain headroom.
  localparam int CW = VW + 32;
  // Square root: 32-bit radicand, one result bit per stage.
  localparam int SQ_BITS = 16;
  localparam int SQ_W    = 2 * VW;

  localparam logic [22:0] ROT_K = 23'd4685083;
  localparam logic [SQ_W-1:0] SAT_LIMIT = SQ_W'(64'd4294901760);
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_C = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_D = 8'd3;

  typedef struct packed {
    logic [15:0] angle_off;
    logic [15:0] y;
    logic [15:0] x;
  } geom_t;

  typedef struct packed {
    logic signed [15:0] fwd_velocity;
    logic signed [15:0] side_velocity;
    logic signed [15:0] turn_rate;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        speed_a;
    logic [15:0]        speed_b;
    logic [15:0]        speed_c;
    logic [15:0]        speed_d;
    logic signed [15:0] angle_a;
    logic signed [15:0] angle_b;
    logic signed [15:0] angle_c;
    logic signed [15:0] angle_d;
  } result_t;

  typedef struct packed {
    logic [VW-1:0] vx;
    logic [VW-1:0] vy;
  } vel_t;

  typedef struct packed {
    logic [17:0]   rem;
    logic [15:0]   root;
    logic [31:0]   nbits;
    logic          sat;
    logic          zero;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   z;
  } lane_t;

  // atan(2^-k) in 32-bit binary angle units.
  function automatic logic [31:0] atan_bam(input int k);
    logic [31:0] a;
    case (k)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/swk_front.sv
// Front stages: rotation terms and module velocity vectors, three register stages.
module swk_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  swk_pkg::cmd_t                            cmd,
  input  swk_pkg::geom_t [swk_pkg::NUM_MODULES-1:0] geom,
  output logic                                     out_valid,
  output swk_pkg::vel_t  [swk_pkg::NUM_MODULES-1:0] vel
);

  localparam int NM = swk_pkg::NUM_MODULES;
  localparam int VW = swk_pkg::VW;

  logic              v1, v2;
  logic [15:0]       fwd1, side1, fwd2, side2;
  logic [31:0]       px1 [NM];
  logic [31:0]       py1 [NM];
  logic [53:0]       prx2 [NM];
  logic [53:0]       pry2 [NM];
  logic              nx2 [NM];
  logic              ny2 [NM];

  logic signed [31:0] turn_w;
  logic signed [31:0] rx_w [NM];
  logic signed [31:0] ry_w [NM];
  logic [31:0]        ax [NM];
  logic [31:0]        ay [NM];
  logic [54:0]        sx [NM];
  logic [54:0]        sy [NM];
  logic [VW-1:0]      tx [NM];
  logic [VW-1:0]      ty [NM];

  always_comb begin
    turn_w = {{16{cmd.turn_rate[15]}}, cmd.turn_rate};
    for (int m = 0; m < NM; m++) begin
      rx_w[m] = {{16{geom[m].x[15]}}, geom[m].x};
      ry_w[m] = {{16{geom[m].y[15]}}, geom[m].y};
      ax[m]   = px1[m][31] ? (32'd0 - px1[m]) : px1[m];
      ay[m]   = py1[m][31] ? (32'd0 - py1[m]) : py1[m];
      // Round half up on the magnitude, then restore the sign.
      sx[m]   = {1'b0, prx2[m]} + 55'h0_8000_0000;
      sy[m]   = {1'b0, pry2[m]} + 55'h0_8000_0000;
      tx[m]   = nx2[m] ? (VW'(0) - sx[m][32+VW-1:32]) : sx[m][32+VW-1:32];
      ty[m]   = ny2[m] ? (VW'(0) - sy[m][32+VW-1:32]) : sy[m][32+VW-1:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd1  <= cmd.fwd_velocity;
      side1 <= cmd.side_velocity;
      fwd2  <= fwd1;
      side2 <= side1;
      for (int m = 0; m < NM; m++) begin
        px1[m]  <= turn_w * rx_w[m];
        py1[m]  <= turn_w * ry_w[m];
        prx2[m] <= ax[m][30:0] * swk_pkg::ROT_K;
        pry2[m] <= ay[m][30:0] * swk_pkg::ROT_K;
        nx2[m]  <= px1[m][31];
        ny2[m]  <= py1[m][31];
        vel[m].vx <= {{(VW-16){fwd2[15]}}, fwd2} - ty[m];
        vel[m].vy <= {{(VW-16){side2[15]}}, side2} + tx[m];
      end
    end
  end

endmodule

>>> rtl/core/swk_prep.sv
// Preparation stages: squared magnitude for the root and CORDIC start vectors.
module swk_prep (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  swk_pkg::vel_t  [swk_pkg::NUM_MODULES-1:0] vel,
  output logic                                     out_valid,
  output swk_pkg::lane_t [swk_pkg::NUM_MODULES-1:0] lanes
);

  localparam int NM   = swk_pkg::NUM_MODULES;
  localparam int VW   = swk_pkg::VW;
  localparam int CW   = swk_pkg::CW;
  localparam int SQ_W = swk_pkg::SQ_W;

  logic                v1;
  logic [SQ_W-1:0]     sqx [NM];
  logic [SQ_W-1:0]     sqy [NM];
  logic [CW-1:0]       x1 [NM];
  logic [CW-1:0]       y1 [NM];
  logic                neg1 [NM];
  logic                zero1 [NM];

  logic signed [SQ_W-1:0] vxw [NM];
  logic signed [SQ_W-1:0] vyw [NM];
  logic [CW-1:0]          xs [NM];
  logic [CW-1:0]          ys [NM];
  logic [SQ_W-1:0]        nsum [NM];

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      vxw[m]  = {{(SQ_W-VW){vel[m].vx[VW-1]}}, vel[m].vx};
      vyw[m]  = {{(SQ_W-VW){vel[m].vy[VW-1]}}, vel[m].vy};
      xs[m]   = {{(CW-VW-30){vel[m].vx[VW-1]}}, vel[m].vx, 30'd0};
      ys[m]   = {{(CW-VW-30){vel[m].vy[VW-1]}}, vel[m].vy, 30'd0};
      nsum[m] = sqx[m] + sqy[m];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < NM; m++) begin
        sqx[m]   <= vxw[m] * vxw[m];
        sqy[m]   <= vyw[m] * vyw[m];
        // Left half plane: rotate by half a turn so CORDIC converges.
        neg1[m]  <= vel[m].vx[VW-1];
        x1[m]    <= vel[m].vx[VW-1] ? (CW'(0) - xs[m]) : xs[m];
        y1[m]    <= vel[m].vx[VW-1] ? (CW'(0) - ys[m]) : ys[m];
        zero1[m] <= (vel[m].vx == '0) && (vel[m].vy == '0);

        lanes[m].rem   <= '0;
        lanes[m].root  <= '0;
        lanes[m].nbits <= nsum[m][31:0];
        lanes[m].sat   <= nsum[m] > swk_pkg::SAT_LIMIT;
        lanes[m].zero  <= zero1[m];
        lanes[m].x     <= x1[m];
        lanes[m].y     <= y1[m];
        lanes[m].z     <= neg1[m] ? swk_pkg::HALF_TURN : 32'd0;
      end
    end
  end

endmodule

>>> rtl/core/swk_iter.sv
// One iteration stage: a restoring square-root step and a CORDIC vectoring step.
module swk_iter #(
  parameter int K     = 0,
  parameter int STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  swk_pkg::lane_t [swk_pkg::NUM_MODULES-1:0] in_lanes,
  output logic                                     out_valid,
  output swk_pkg::lane_t [swk_pkg::NUM_MODULES-1:0] out_lanes
);

  localparam int NM = swk_pkg::NUM_MODULES;
  localparam int CW = swk_pkg::CW;
  localparam logic DoSqrt   = (K < swk_pkg::SQ_BITS);
  localparam logic DoCordic = (K < STEPS);
  localparam logic [31:0] Angle = swk_pkg::atan_bam(K);

  swk_pkg::lane_t [NM-1:0] nxt;
  logic [17:0]             acc [NM];
  logic [17:0]             trial [NM];
  logic [CW-1:0]           xsh [NM];
  logic [CW-1:0]           ysh [NM];

  always_comb begin
    nxt = in_lanes;
    for (int m = 0; m < NM; m++) begin
      acc[m]   = {in_lanes[m].rem[15:0], in_lanes[m].nbits[31:30]};
      trial[m] = {in_lanes[m].root, 2'b01};
      xsh[m]   = $unsigned($signed(in_lanes[m].x) >>> K);
      ysh[m]   = $unsigned($signed(in_lanes[m].y) >>> K);
      if (DoSqrt) begin
        nxt[m].nbits = {in_lanes[m].nbits[29:0], 2'b00};
        if (acc[m] >= trial[m]) begin
          nxt[m].rem  = acc[m] - trial[m];
          nxt[m].root = {in_lanes[m].root[14:0], 1'b1};
        end else begin
          nxt[m].rem  = acc[m];
          nxt[m].root = {in_lanes[m].root[14:0], 1'b0};
        end
      end
      if (DoCordic) begin
        if (!in_lanes[m].y[CW-1] && (in_lanes[m].y != '0)) begin
          nxt[m].x = in_lanes[m].x + ysh[m];
          nxt[m].y = in_lanes[m].y - xsh[m];
          nxt[m].z = in_lanes[m].z + Angle;
        end else begin
          nxt[m].x = in_lanes[m].x - ysh[m];
          nxt[m].y = in_lanes[m].y + xsh[m];
          nxt[m].z = in_lanes[m].z - Angle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lanes <= nxt;
    end
  end

endmodule

>>> rtl/core/swerve_module_kinematics_top.sv
// Top level of the swerve inverse kinematics block: config registers, pipeline, output.
//
// Use: a body velocity command (forward, sideways, turn rate) is offered on
// cmd with cmd_valid/cmd_ready; each accepted beat yields exactly one result
// beat on res with res_valid/res_ready, carrying speed and steering angle for
// the four wheel modules in command order.
// Geometry of module a..d (x, y offsets and steering offset) is written on the
// cfg channel at index 0..3; cfg_ready is always high, other indexes are
// dropped. Geometry should only change while no command is in flight.
// An accepted command passes the front, preparation and iteration stages and
// the output register. Throughput: one command per cycle unless the output
// stalls, set by fully pipelined square-root and CORDIC stages, one step each.
// Reset clears every stage valid bit and all geometry registers to zero.
// When the receiver stalls, the whole pipeline holds in place, cmd_ready
// drops, and nothing is lost or repeated; bubbles inside the pipeline stay
// where they are while the output beat waits.
module swerve_module_kinematics_top #(
  parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  swk_pkg::cmd_t                   cmd,
  output logic                            res_valid,
  input  logic                            res_ready,
  output swk_pkg::result_t                res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [47:0]                     cfg_data
);

  localparam int NM    = swk_pkg::NUM_MODULES;
  localparam int DEPTH = (CORDIC_STEPS > swk_pkg::SQ_BITS) ? CORDIC_STEPS : swk_pkg::SQ_BITS;

  swk_pkg::geom_t [NM-1:0] geom;

  // The whole pipeline moves when the output register is empty or being read.
  logic adv;
  assign adv       = !res_valid || res_ready;
  assign cmd_ready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swk_pkg::REG_MODULE_A: geom[0] <= cfg_data;
        swk_pkg::REG_MODULE_B: geom[1] <= cfg_data;
        swk_pkg::REG_MODULE_C: geom[2] <= cfg_data;
        swk_pkg::REG_MODULE_D: geom[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                    front_valid;
  swk_pkg::vel_t [NM-1:0]  vel;

  swk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cmd_valid),
    .cmd       (cmd),
    .geom      (geom),
    .out_valid (front_valid),
    .vel       (vel)
  );

  logic                    chain_valid [DEPTH+1];
  swk_pkg::lane_t [NM-1:0] chain [DEPTH+1];

  swk_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (front_valid),
    .vel       (vel),
    .out_valid (chain_valid[0]),
    .lanes     (chain[0])
  );

  // One stage per root bit and per CORDIC step; the shorter chain passes through.
  for (genvar k = 0; k < DEPTH; k++) begin : g_iter
    swk_iter #(
      .K     (k),
      .STEPS (CORDIC_STEPS)
    ) u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (chain_valid[k]),
      .in_lanes  (chain[k]),
      .out_valid (chain_valid[k+1]),
      .out_lanes (chain[k+1])
    );
  end

  // Output stage: round the root, saturate, round the angle and add the offset.
  swk_pkg::lane_t [NM-1:0] last;
  logic [15:0]             speed [NM];
  logic [15:0]             angle [NM];
  logic [31:0]             zr [NM];

  assign last = chain[DEPTH];

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      zr[m] = last[m].z + 32'h0000_8000;
      if (last[m].sat) begin
        speed[m] = 16'hFFFF;
      end else if (last[m].rem > {2'b00, last[m].root}) begin
        speed[m] = last[m].root + 16'd1;
      end else begin
        speed[m] = last[m].root;
      end
      // A zero vector steers straight to the module offset.
      angle[m] = last[m].zero ? geom[m].angle_off : (zr[m][31:16] + geom[m].angle_off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= chain_valid[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.speed_a <= speed[0];
      res.speed_b <= speed[1];
      res.speed_c <= speed[2];
      res.speed_d <= speed[3];
      res.angle_a <= angle[0];
      res.angle_b <= angle[1];
      res.angle_c <= angle[2];
      res.angle_d <= angle[3];
    end
  end

endmodule
